>>> src/vtio_pkg.sv
// ----------------------------------------------------------------------------
// vtio_pkg
// Types and constants shared by the terminal port modules.
// ----------------------------------------------------------------------------
package vtio_pkg;

   localparam int RX_DEPTH = 128;
   localparam int TX_DEPTH = 512;
   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);
   localparam int TX_CW = $clog2(TX_DEPTH + 1);

   localparam logic [2:0] MODE_READ    = 3'd0;
   localparam logic [2:0] MODE_WRITE   = 3'd1;
   localparam logic [2:0] MODE_HOST    = 3'd2;
   localparam logic [2:0] MODE_DRAIN   = 3'd3;
   localparam logic [2:0] MODE_LINK    = 3'd4;
   localparam logic [2:0] MODE_RESTART = 3'd5;

   localparam logic [7:0] ESC_BYTE    = 8'h1D;
   localparam logic [7:0] RESULT_PORT = 8'hFE;
   localparam logic [7:0] PASS_BYTE   = 8'h5A;
   localparam logic [7:0] FAIL_BYTE   = 8'hE1;
   localparam logic [7:0] TEST_XOR    = 8'hA5;
   localparam logic [7:0] DATA_PORT   = 8'h00;
   localparam logic [7:0] STATUS_PORT = 8'h01;
   localparam logic [7:0] OTHER_READ  = 8'hFF;
   localparam logic [2:0] SEQ_LEN     = 3'd5;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] port;
      logic [7:0] data;
      logic       link_now;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        command_valid;
      logic [7:0]  command_code;
      logic [31:0] rx_drop_count;
      logic [31:0] tx_drop_count;
      logic [31:0] ram_fail_count;
      logic [31:0] test_error_count;
      logic [2:0]  test_step;
      logic        test_complete;
   } rsp_type;

   function automatic logic [7:0] seq_port(input logic [2:0] i);
      logic [7:0] r;
      r = 8'h00;
      unique case (i)
         3'd0: r = 8'h00;
         3'd1: r = 8'h01;
         3'd2: r = 8'h55;
         3'd3: r = 8'hAA;
         3'd4: r = 8'hFF;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

>>> src/virtual_terminal_io_port_core.sv
// An item's result passes the queue slot and then the back part's result register;
// a receive pop or a transmit drain also passes the read wait state.
// One item per cycle while the output is not stalled; a FIFO read holds the next item in the read wait state.
// Each FIFO memory has one write and one registered read port.
// Synchronous reset clears pointers, counters and flags; FIFO contents are
// left as they are; only bytes that were written are ever returned.
// ----------------------------------------------------------------------------
// virtual_terminal_io_port_core
// Terminal port top level: front queue feeding the executing back part.
// ----------------------------------------------------------------------------
module virtual_terminal_io_port_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  vtio_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vtio_pkg::rsp_type rsp_payload
);
   logic              mode_ff;
   logic              q_valid, q_stall;
   vtio_pkg::req_type q_item;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b0;
      else if (csr_write_enable) mode_ff <= csr_write_data;
   end

   vtio_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall), .in_item(req_payload),
      .out_valid(q_valid), .out_stall(q_stall), .out_item(q_item)
   );

   vtio_back u_back (
      .clock(clock), .reset(reset), .self_test(mode_ff),
      .in_valid(q_valid), .in_stall(q_stall), .in_item(q_item),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_item(rsp_payload)
   );

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.test_step <= vtio_pkg::SEQ_LEN)
      else $error("test step out of range");
   a_tx_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.command_valid |-> rsp_payload.command_code == 8'h00)
      else $error("command code without command");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");
endmodule

>>> src/vtio_queue.sv
// ----------------------------------------------------------------------------
// vtio_queue
// Two-entry item queue between the front and the back part.
// ----------------------------------------------------------------------------
module vtio_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  vtio_pkg::req_type in_item,
   output logic              out_valid,
   input  logic              out_stall,
   output vtio_pkg::req_type out_item
);
   vtio_pkg::req_type slot_ff [2];
   logic              wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = slot_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wp_ff] <= in_item;
   end
endmodule

>>> src/vtio_back.sv
// ----------------------------------------------------------------------------
// vtio_back
// Executes items: FIFOs, escape filter, counters and self-test checker.
// ----------------------------------------------------------------------------
module vtio_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              self_test,
   input  logic              in_valid,
   output logic              in_stall,
   input  vtio_pkg::req_type in_item,
   output logic              out_valid,
   input  logic              out_stall,
   output vtio_pkg::rsp_type out_item
);
   typedef enum logic [1:0] {
      ST_EXEC = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [7:0] rx_mem [vtio_pkg::RX_DEPTH];
   logic [7:0] tx_mem [vtio_pkg::TX_DEPTH];
   logic [7:0] rx_q, tx_q;

   logic [vtio_pkg::RX_AW-1:0] rx_rp_ff, rx_rp_in, rx_wp_ff, rx_wp_in;
   logic [vtio_pkg::RX_CW-1:0] rx_fill_ff, rx_fill_in;
   logic [vtio_pkg::TX_AW-1:0] tx_rp_ff, tx_rp_in, tx_wp_ff, tx_wp_in;
   logic [vtio_pkg::TX_CW-1:0] tx_fill_ff, tx_fill_in;
   logic        link_ff, link_in, esc_ff, esc_in;
   logic [31:0] rxd_ff, rxd_in, txd_ff, txd_in, ram_ff, ram_in, terr_ff, terr_in;
   logic [2:0]  tpos_ff, tpos_in;
   logic        tdone_ff, tdone_in;

   logic        ov_ff, ov_in;
   vtio_pkg::rsp_type rsp_ff, rsp_in;
   logic        rd_rx_ff, rd_rx_in, rd_tx_ff, rd_tx_in;

   logic rx_we, tx_we, take, out_free;
   logic [7:0] we_data;

   function automatic logic [vtio_pkg::RX_AW-1:0] rx_next(
      input logic [vtio_pkg::RX_AW-1:0] p);
      return (p == vtio_pkg::RX_AW'(vtio_pkg::RX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction
   function automatic logic [vtio_pkg::TX_AW-1:0] tx_next(
      input logic [vtio_pkg::TX_AW-1:0] p);
      return (p == vtio_pkg::TX_AW'(vtio_pkg::TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign out_free  = !ov_ff || !out_stall;
   assign in_stall  = (state_ff != ST_EXEC) || !out_free;
   assign take      = in_valid && !in_stall;
   assign out_valid = ov_ff && (state_ff == ST_EXEC);

   always_comb begin
      out_item = rsp_ff;
      if (rd_rx_ff) out_item.read_data = rx_q;
      if (rd_tx_ff) out_item.tx_byte = tx_q;
   end

   always_comb begin
      logic rx_push;
      logic full_rx;
      rx_push = 1'b0;
      full_rx = 1'b0;
      state_in = state_ff;
      rx_rp_in = rx_rp_ff; rx_wp_in = rx_wp_ff; rx_fill_in = rx_fill_ff;
      tx_rp_in = tx_rp_ff; tx_wp_in = tx_wp_ff; tx_fill_in = tx_fill_ff;
      link_in = link_ff; esc_in = esc_ff;
      rxd_in = rxd_ff; txd_in = txd_ff; ram_in = ram_ff; terr_in = terr_ff;
      tpos_in = tpos_ff; tdone_in = tdone_ff;
      rx_we = 1'b0; tx_we = 1'b0; we_data = in_item.data;
      rd_rx_in = rd_rx_ff; rd_tx_in = rd_tx_ff;
      // The held result is released only when it is actually presented and taken.
      ov_in = ov_ff && !(out_valid && !out_stall);
      rsp_in = rsp_ff;
      if (state_ff == ST_READ) begin
         state_in = ST_EXEC;
      end
      if (take) begin
         rsp_in = '0;
         rd_rx_in = 1'b0;
         rd_tx_in = 1'b0;
         ov_in = 1'b1;
         unique case (in_item.mode)
            vtio_pkg::MODE_READ: begin
               if (self_test) begin
                  rsp_in.read_data = in_item.port ^ vtio_pkg::TEST_XOR;
               end else if (in_item.port == vtio_pkg::DATA_PORT) begin
                  if (rx_fill_ff != '0) begin
                     rd_rx_in = 1'b1;
                     state_in = ST_READ;
                     rx_rp_in = rx_next(rx_rp_ff);
                     rx_fill_in = rx_fill_ff - 1'b1;
                  end
               end else if (in_item.port == vtio_pkg::STATUS_PORT) begin
                  rsp_in.read_data = {link_ff, 5'd0,
                     tx_fill_ff < vtio_pkg::TX_CW'(vtio_pkg::TX_DEPTH),
                     rx_fill_ff != '0};
               end else begin
                  rsp_in.read_data = vtio_pkg::OTHER_READ;
               end
            end
            vtio_pkg::MODE_WRITE: begin
               if (self_test) begin
                  if (in_item.port == vtio_pkg::RESULT_PORT) begin
                     if (!(in_item.data == vtio_pkg::PASS_BYTE &&
                           tpos_ff == vtio_pkg::SEQ_LEN && terr_ff == '0))
                        terr_in = terr_ff + 1'b1;
                     tdone_in = 1'b1;
                  end else if (tpos_ff >= vtio_pkg::SEQ_LEN ||
                        in_item.port != vtio_pkg::seq_port(tpos_ff) ||
                        in_item.data != vtio_pkg::seq_port(tpos_ff)) begin
                     terr_in = terr_ff + 1'b1;
                  end else begin
                     tpos_in = tpos_ff + 1'b1;
                  end
               end else if (in_item.port == vtio_pkg::RESULT_PORT &&
                     in_item.data == vtio_pkg::FAIL_BYTE) begin
                  ram_in = ram_ff + 1'b1;
               end else if (in_item.port == vtio_pkg::DATA_PORT) begin
                  if (tx_fill_ff >= vtio_pkg::TX_CW'(vtio_pkg::TX_DEPTH)) begin
                     txd_in = txd_ff + 1'b1;
                  end else begin
                     tx_we = 1'b1;
                     tx_wp_in = tx_next(tx_wp_ff);
                     tx_fill_in = tx_fill_ff + 1'b1;
                  end
               end
            end
            vtio_pkg::MODE_HOST: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  if (in_item.data == vtio_pkg::ESC_BYTE) begin
                     rx_push = 1'b1;
                  end else begin
                     rsp_in.command_valid = 1'b1;
                     rsp_in.command_code = in_item.data;
                  end
               end else if (in_item.data == vtio_pkg::ESC_BYTE) begin
                  esc_in = 1'b1;
               end else if (!self_test) begin
                  rx_push = 1'b1;
               end
            end
            vtio_pkg::MODE_DRAIN: begin
               if (link_ff && tx_fill_ff != '0) begin
                  rsp_in.tx_valid = 1'b1;
                  rd_tx_in = 1'b1;
                  state_in = ST_READ;
                  tx_rp_in = tx_next(tx_rp_ff);
                  tx_fill_in = tx_fill_ff - 1'b1;
               end
            end
            vtio_pkg::MODE_LINK: begin
               if (link_ff && !in_item.link_now) begin
                  rx_rp_in = '0; rx_wp_in = '0; rx_fill_in = '0;
                  tx_rp_in = '0; tx_wp_in = '0; tx_fill_in = '0;
                  esc_in = 1'b0;
               end
               link_in = in_item.link_now;
            end
            vtio_pkg::MODE_RESTART: begin
               rx_rp_in = '0; rx_wp_in = '0; rx_fill_in = '0;
               tx_rp_in = '0; tx_wp_in = '0; tx_fill_in = '0;
               tpos_in = '0; terr_in = '0; tdone_in = 1'b0;
            end
            default: begin
            end
         endcase
         if (rx_push) begin
            full_rx = rx_fill_ff >= vtio_pkg::RX_CW'(vtio_pkg::RX_DEPTH);
            rx_we = 1'b1;
            rx_wp_in = rx_next(rx_wp_ff);
            if (full_rx) begin
               rx_rp_in = rx_next(rx_rp_ff);
               rxd_in = rxd_ff + 1'b1;
            end else begin
               rx_fill_in = rx_fill_ff + 1'b1;
            end
         end
         rsp_in.rx_drop_count    = rxd_in;
         rsp_in.tx_drop_count    = txd_in;
         rsp_in.ram_fail_count   = ram_in;
         rsp_in.test_error_count = terr_in;
         rsp_in.test_step        = tpos_in;
         rsp_in.test_complete    = tdone_in;
      end
   end

   // Read data is registered when the pop is taken; the held item waits in ST_READ.
   always_ff @(posedge clock) begin
      if (rx_we) rx_mem[rx_wp_ff] <= we_data;
      if (take && in_item.mode == vtio_pkg::MODE_READ) rx_q <= rx_mem[rx_rp_ff];
   end
   always_ff @(posedge clock) begin
      if (tx_we) tx_mem[tx_wp_ff] <= we_data;
      if (take && in_item.mode == vtio_pkg::MODE_DRAIN) tx_q <= tx_mem[tx_rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EXEC;
         rx_rp_ff <= '0; rx_wp_ff <= '0; rx_fill_ff <= '0;
         tx_rp_ff <= '0; tx_wp_ff <= '0; tx_fill_ff <= '0;
         link_ff <= 1'b0; esc_ff <= 1'b0;
         rxd_ff <= '0; txd_ff <= '0; ram_ff <= '0; terr_ff <= '0;
         tpos_ff <= '0; tdone_ff <= 1'b0;
         ov_ff <= 1'b0; rd_rx_ff <= 1'b0; rd_tx_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rx_rp_ff <= rx_rp_in; rx_wp_ff <= rx_wp_in; rx_fill_ff <= rx_fill_in;
         tx_rp_ff <= tx_rp_in; tx_wp_ff <= tx_wp_in; tx_fill_ff <= tx_fill_in;
         link_ff <= link_in; esc_ff <= esc_in;
         rxd_ff <= rxd_in; txd_ff <= txd_in; ram_ff <= ram_in; terr_ff <= terr_in;
         tpos_ff <= tpos_in; tdone_ff <= tdone_in;
         ov_ff <= ov_in; rd_rx_ff <= rd_rx_in; rd_tx_ff <= rd_tx_in;
      end
      rsp_ff <= rsp_in;
   end
endmodule
